FILE: rtl/tlbg_pkg.sv
// Shared types and constants for the text line block grouper.
package tlbg_pkg;
	localparam int POS_W  = 20;
	localparam int SIZE_W = 16;
	localparam int OUT_W  = 6;

	typedef struct packed {
		logic signed [POS_W-1:0]  pos_u;
		logic signed [POS_W-1:0]  pos_v;
		logic        [SIZE_W-1:0] box_w;
		logic        [SIZE_W-1:0] box_h;
		logic        [1:0]        read_quadrant;
		logic                     is_measure;
		logic                     is_heading;
		logic                     in_last;
	} line_req_t;

	typedef struct packed {
		logic [OUT_W-1:0] line_index;
		logic [OUT_W-1:0] block_id;
		logic             out_last;
	} block_res_t;

	// Pair geometry presented to the pair test unit.
	typedef struct packed {
		logic signed [POS_W-1:0]  ua;
		logic signed [POS_W-1:0]  va;
		logic        [SIZE_W-1:0] wa;
		logic        [SIZE_W-1:0] ha;
		logic signed [POS_W-1:0]  ub;
		logic signed [POS_W-1:0]  vb;
		logic        [SIZE_W-1:0] wb;
		logic        [SIZE_W-1:0] hb;
	} pair_geom_t;
endpackage

FILE: rtl/tlbg_if.sv
// Valid/ready channel interface carrying one payload.
interface tlbg_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/tlbg_pair.sv
// Registered pair test unit: the gap, height-ratio and alignment rules in two stages.
module tlbg_pair
	import tlbg_pkg::*;
(
	input  logic       clk,
	input  pair_geom_t geom,
	output logic       ok_s2
);
	localparam int WD = 48;
	typedef logic signed [WD-1:0] wide_t;

	wide_t ua, ub, va, vb, wa, wb, ha, hb;
	wide_t big_h, small_h, max_w, min_w, dv, g2, du, cd, el, er;
	wide_t g2_s1, bh_s1, sh_s1, mw_s1, nw_s1, cd_s1, el_s1, er_s1;

	always_comb begin
		ua = WD'(geom.ua);
		ub = WD'(geom.ub);
		va = WD'(geom.va);
		vb = WD'(geom.vb);
		wa = wide_t'({32'd0, geom.wa});
		wb = wide_t'({32'd0, geom.wb});
		ha = wide_t'({32'd0, geom.ha});
		hb = wide_t'({32'd0, geom.hb});
		big_h   = (ha > hb) ? ha : hb;
		small_h = (ha > hb) ? hb : ha;
		max_w   = (wa > wb) ? wa : wb;
		min_w   = (wa > wb) ? wb : wa;
		dv = vb - va;
		if (dv < 0) begin
			dv = -dv;
		end
		g2 = (dv <<< 1) - (ha + hb);
		du = ua - ub;
		cd = (du < 0) ? -du : du;
		el = ((ua <<< 1) - wa) - ((ub <<< 1) - wb);
		if (el < 0) begin
			el = -el;
		end
		er = ((ua <<< 1) + wa) - ((ub <<< 1) + wb);
		if (er < 0) begin
			er = -er;
		end
	end

	always_ff @(posedge clk) begin
		g2_s1 <= g2;
		bh_s1 <= big_h;
		sh_s1 <= small_h;
		mw_s1 <= max_w;
		nw_s1 <= min_w;
		cd_s1 <= cd;
		el_s1 <= el;
		er_s1 <= er;
	end

	logic in_gap, centered, similar, left_ok, right_ok, tight, close, height_ok;
	always_comb begin
		in_gap    = !((g2_s1 * 100) < -(bh_s1 * 150)) && !((g2_s1 * 100) > (bh_s1 * 850));
		centered  = (cd_s1 * 100) <= (mw_s1 * 25);
		similar   = (mw_s1 * 10) <= (nw_s1 * 18);
		left_ok   = similar && (el_s1 <= (bh_s1 <<< 2));
		right_ok  = similar && (er_s1 <= (bh_s1 <<< 2));
		tight     = (cd_s1 * 100) <= (mw_s1 * 12);
		close     = (g2_s1 * 100) <= (bh_s1 * 250);
		height_ok = ((bh_s1 * 10) <= (sh_s1 * 18))
			|| (((bh_s1 * 10) <= (sh_s1 * 22)) && tight && close);
	end

	always_ff @(posedge clk) begin
		ok_s2 <= in_gap && height_ok && (centered || left_ok || right_ok);
	end
endmodule

FILE: rtl/text_line_block_grouper.sv
// Top level of the text line block grouper: line store, sequencer and result output.
// Lines are loaded one per request into internal memories of MAX_LINES entries; widths
// and heights below one pixel are raised to one pixel, and a line that arrives while the
// store is full is dropped. A request with in_last starts grouping, and the block is not
// ready again until the last result has been registered for output. Every union-find
// lookup walks one parent step per pass through S_FIND, S_FRD and S_FGP, the step that
// reaches the root included. Grouping first resets the parent links in S_INIT, then
// tests every ordered pair i < j whose line i is not a measurement with a single shared
// pair unit: each pair passes through the operand read, the two-stage pair test and the
// loop step, each line adds its own step in S_PI, and a merge adds the lookups of both
// roots. Block keys then take one lookup per line, ranking blocks by (min v, min u, root)
// compares one pair of keys at a time, and each result takes its own lookup and is held
// while the receiver holds off. There is no clearing pass after reset.
module text_line_block_grouper
	import tlbg_pkg::*;
#(
	parameter int MAX_LINES = 64,
	parameter int FRAC_BITS = 4
) (
	input  logic clk,
	input  logic arst_n,
	tlbg_if.sink   line_in,
	tlbg_if.source block_out
);
	localparam int IW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
	localparam int CW = IW + 1;
	localparam logic [SIZE_W-1:0] ONE_UNIT = SIZE_W'(1 << FRAC_BITS);

	// Sequencer states.
	localparam logic [4:0] S_LOAD   = 5'd0;
	localparam logic [4:0] S_INIT   = 5'd1;
	localparam logic [4:0] S_PI     = 5'd2;
	localparam logic [4:0] S_PJ     = 5'd3;
	localparam logic [4:0] S_PRD    = 5'd4;
	localparam logic [4:0] S_PW1    = 5'd5;
	localparam logic [4:0] S_PW2    = 5'd6;
	localparam logic [4:0] S_PW3    = 5'd7;
	localparam logic [4:0] S_FIND   = 5'd8;
	localparam logic [4:0] S_FRD    = 5'd9;
	localparam logic [4:0] S_FGP    = 5'd10;
	localparam logic [4:0] S_UNION  = 5'd11;
	localparam logic [4:0] S_KSTART = 5'd12;
	localparam logic [4:0] S_KRD    = 5'd13;
	localparam logic [4:0] S_KRK    = 5'd14;
	localparam logic [4:0] S_KUPD   = 5'd15;
	localparam logic [4:0] S_RI     = 5'd16;
	localparam logic [4:0] S_RJ     = 5'd17;
	localparam logic [4:0] S_RCMP   = 5'd18;
	localparam logic [4:0] S_RWR    = 5'd19;
	localparam logic [4:0] S_OSTART = 5'd20;
	localparam logic [4:0] S_ORK    = 5'd21;
	localparam logic [4:0] S_OMAP   = 5'd22;
	localparam logic [4:0] S_OOUT   = 5'd23;

	// Find return targets.
	localparam logic [1:0] F_J   = 2'd0;
	localparam logic [1:0] F_I   = 2'd1;
	localparam logic [1:0] F_KEY = 2'd2;
	localparam logic [1:0] F_OUT = 2'd3;

	// Line and grouping memories (line data written at load, all read in the clocked block below).
	logic [2*POS_W-1:0]  pos_mem  [MAX_LINES];
	logic [2*SIZE_W-1:0] size_mem [MAX_LINES];
	logic [3:0]          tag_mem  [MAX_LINES];
	logic [IW-1:0]       par_mem  [MAX_LINES];
	logic [2*POS_W+IW-1:0] key_mem [MAX_LINES];
	logic [IW-1:0]       map_mem  [MAX_LINES];
	logic [MAX_LINES-1:0] seen_q;

	logic [4:0]    state_q;
	logic [1:0]    ftgt_q;
	logic [CW-1:0] count_q, n_q;
	logic [IW-1:0] i_q, j_q, x_q, ri_q, rank_q;

	// Registered memory read data.
	logic [2*POS_W-1:0]  pos_a_q, pos_b_q;
	logic [2*SIZE_W-1:0] size_a_q, size_b_q;
	logic [3:0]          tag_a_q, tag_b_q;
	logic [IW-1:0]       par_rd_q, par2_rd_q, map_rd_q;
	logic [2*POS_W+IW-1:0] key_a_q, key_b_q;

	logic          rd_sel_q;   // 0: read line a address i_q, 1: line b address j_q
	pair_geom_t    geom;
	logic          pair_ok_s2;
	block_res_t    res_q;
	logic          res_valid_q;

	assign line_in.ready   = (state_q == S_LOAD);
	assign block_out.valid = res_valid_q;
	assign block_out.payload = res_q;

	logic load_fire;
	assign load_fire = line_in.valid && line_in.ready;

	always_comb begin
		geom.ua = pos_a_q[POS_W-1:0];
		geom.va = pos_a_q[2*POS_W-1:POS_W];
		geom.wa = size_a_q[SIZE_W-1:0];
		geom.ha = size_a_q[2*SIZE_W-1:SIZE_W];
		geom.ub = pos_b_q[POS_W-1:0];
		geom.vb = pos_b_q[2*POS_W-1:POS_W];
		geom.wb = size_b_q[SIZE_W-1:0];
		geom.hb = size_b_q[2*SIZE_W-1:SIZE_W];
	end

	tlbg_pair u_pair (
		.clk  (clk),
		.geom (geom),
		.ok_s2(pair_ok_s2)
	);

	// Key of line a as a (v, u, root) tuple; signed fields flipped for unsigned compare.
	logic [2*POS_W+IW-1:0] key_line;
	assign key_line = {~pos_a_q[2*POS_W-1], pos_a_q[2*POS_W-2:POS_W],
		~pos_a_q[POS_W-1], pos_a_q[POS_W-2:0], x_q};

	logic [SIZE_W-1:0] ld_w, ld_h;
	always_comb begin
		ld_w = (line_in.payload.box_w < ONE_UNIT) ? ONE_UNIT : line_in.payload.box_w;
		ld_h = (line_in.payload.box_h < ONE_UNIT) ? ONE_UNIT : line_in.payload.box_h;
	end

	logic upper_head;
	always_comb begin
		upper_head = ($signed(pos_a_q[2*POS_W-1:POS_W]) <= $signed(pos_b_q[2*POS_W-1:POS_W]))
			? tag_a_q[3] : tag_b_q[3];
	end

	// Memory writes and reads.
	always_ff @(posedge clk) begin
		if (load_fire && (count_q < CW'(MAX_LINES))) begin
			pos_mem[count_q[IW-1:0]]  <= {line_in.payload.pos_v, line_in.payload.pos_u};
			size_mem[count_q[IW-1:0]] <= {ld_h, ld_w};
			tag_mem[count_q[IW-1:0]]  <= {line_in.payload.is_heading, line_in.payload.is_measure,
				line_in.payload.read_quadrant};
		end
		if (rd_sel_q) begin
			pos_b_q  <= pos_mem[j_q];
			size_b_q <= size_mem[j_q];
			tag_b_q  <= tag_mem[j_q];
			key_b_q  <= key_mem[j_q];
		end else begin
			pos_a_q  <= pos_mem[i_q];
			size_a_q <= size_mem[i_q];
			tag_a_q  <= tag_mem[i_q];
			key_a_q  <= key_mem[i_q];
		end
		par_rd_q  <= par_mem[x_q];
		par2_rd_q <= par_mem[par_rd_q];
		map_rd_q  <= map_mem[x_q];
		if (state_q == S_INIT) begin
			par_mem[i_q] <= i_q;
		end else if (state_q == S_FGP && par_rd_q != x_q) begin
			par_mem[x_q] <= par2_rd_q;
		end else if (state_q == S_UNION && ftgt_q == F_J) begin
			par_mem[ri_q] <= x_q;
		end
		if (state_q == S_KUPD) begin
			if (!seen_q[x_q]) begin
				key_mem[x_q] <= key_line;
			end else begin
				key_mem[x_q] <= {(key_line[2*POS_W+IW-1:POS_W+IW] < key_b_q[2*POS_W+IW-1:POS_W+IW])
					? key_line[2*POS_W+IW-1:POS_W+IW] : key_b_q[2*POS_W+IW-1:POS_W+IW],
					(key_line[POS_W+IW-1:IW] < key_b_q[POS_W+IW-1:IW])
					? key_line[POS_W+IW-1:IW] : key_b_q[POS_W+IW-1:IW],
					key_b_q[IW-1:0]};
			end
		end
		if (state_q == S_RWR) begin
			map_mem[i_q] <= rank_q;
		end
	end

	// Sequencer. The find walk reads par[x] (S_FIND -> S_FRD), then par[par[x]] (S_FGP),
	// writes the halved link and hops until x is its own parent.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			ftgt_q      <= F_J;
			count_q     <= '0;
			n_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			x_q         <= '0;
			ri_q        <= '0;
			rank_q      <= '0;
			rd_sel_q    <= 1'b0;
			seen_q      <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (state_q == S_OOUT && (!res_valid_q || block_out.ready)) begin
				res_valid_q <= 1'b1;
			end else if (block_out.valid && block_out.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_LOAD: begin
					if (load_fire) begin
						if (line_in.payload.in_last) begin
							n_q     <= (count_q < CW'(MAX_LINES)) ? count_q + CW'(1) : count_q;
							count_q <= '0;
							i_q     <= '0;
							state_q <= ((count_q == '0) && (MAX_LINES < 1)) ? S_LOAD : S_INIT;
						end else if (count_q < CW'(MAX_LINES)) begin
							count_q <= count_q + CW'(1);
						end
					end
				end
				S_INIT: begin
					if (CW'(i_q) + CW'(1) >= n_q) begin
						i_q      <= '0;
						rd_sel_q <= 1'b0;
						state_q  <= S_PI;
					end else begin
						i_q <= i_q + IW'(1);
					end
				end
				S_PI: begin
					// line a read is issued with rd_sel_q low; next pick j.
					if (CW'(i_q) + CW'(1) >= n_q) begin
						seen_q  <= '0;
						i_q     <= '0;
						state_q <= S_KSTART;
					end else begin
						j_q      <= i_q + IW'(1);
						rd_sel_q <= 1'b1;
						state_q  <= S_PJ;
					end
				end
				S_PJ: begin
					// a data valid now; b read issued this edge.
					if (tag_a_q[2]) begin
						rd_sel_q <= 1'b0;
						i_q      <= i_q + IW'(1);
						state_q  <= S_PI;
					end else begin
						state_q <= S_PRD;
					end
				end
				S_PRD: state_q <= S_PW1;
				S_PW1: state_q <= S_PW2;
				S_PW2: state_q <= S_PW3;
				S_PW3: begin
					if (!tag_b_q[2] && (tag_a_q[1:0] == tag_b_q[1:0]) && pair_ok_s2
						&& !upper_head) begin
						x_q      <= j_q;
						ftgt_q   <= F_J;
						state_q  <= S_FIND;
					end else begin
						state_q <= S_UNION;
						ftgt_q  <= F_KEY;
					end
				end
				S_FIND: state_q <= S_FRD;
				S_FRD: state_q <= S_FGP;
				S_FGP: begin
					if (par_rd_q == x_q) begin
						unique case (ftgt_q)
							F_J: begin
								ri_q    <= x_q;
								x_q     <= i_q;
								ftgt_q  <= F_I;
								state_q <= S_FIND;
							end
							F_I: begin
								// ri_q holds root of j, x_q root of i: swap for the write.
								x_q     <= ri_q;
								ri_q    <= x_q;
								ftgt_q  <= F_J;
								state_q <= S_UNION;
							end
							F_KEY: begin
								// Fetch the root's key through j_q.
								j_q      <= x_q;
								rd_sel_q <= 1'b1;
								state_q  <= S_KRK;
							end
							F_OUT: state_q <= S_OMAP;
							default: state_q <= S_LOAD;
						endcase
					end else begin
						x_q     <= par2_rd_q;
						state_q <= S_FIND;
					end
				end
				S_UNION: begin
					// Reached with ftgt F_J after a merge, F_KEY after a skip.
					ftgt_q <= F_J;
					if (CW'(j_q) + CW'(1) >= n_q) begin
						rd_sel_q <= 1'b0;
						i_q      <= i_q + IW'(1);
						state_q  <= S_PI;
					end else begin
						j_q     <= j_q + IW'(1);
						state_q <= S_PJ;
					end
				end
				S_KSTART: begin
					rd_sel_q <= 1'b0;
					x_q      <= i_q;
					ftgt_q   <= F_KEY;
					state_q  <= S_KRD;
				end
				S_KRD: state_q <= S_FIND;
				S_KUPD: begin
					// key_b_q must hold the root's key: fetched through j_q in S_KRK.
					seen_q[x_q] <= 1'b1;
					if (CW'(i_q) + CW'(1) >= n_q) begin
						i_q     <= '0;
						state_q <= S_RI;
					end else begin
						i_q     <= i_q + IW'(1);
						state_q <= S_KSTART;
					end
				end
				S_KRK: begin
					rd_sel_q <= 1'b0;
					state_q  <= S_KUPD;
				end
				S_RI: begin
					rank_q   <= '0;
					j_q      <= '0;
					rd_sel_q <= 1'b0;
					state_q  <= seen_q[i_q] ? S_RJ : S_RWR;
				end
				S_RJ: begin
					rd_sel_q <= 1'b1;
					state_q  <= S_RCMP;
				end
				S_RCMP: begin
					if (rd_sel_q) begin
						rd_sel_q <= 1'b0;
					end else begin
						if (seen_q[j_q] && (key_b_q < key_a_q)) begin
							rank_q <= rank_q + IW'(1);
						end
						if (CW'(j_q) + CW'(1) >= n_q) begin
							state_q <= S_RWR;
						end else begin
							j_q      <= j_q + IW'(1);
							rd_sel_q <= 1'b1;
						end
					end
				end
				S_RWR: begin
					if (CW'(i_q) + CW'(1) >= n_q) begin
						i_q     <= '0;
						state_q <= S_OSTART;
					end else begin
						i_q     <= i_q + IW'(1);
						state_q <= S_RI;
					end
				end
				S_OSTART: begin
					if (!res_valid_q || block_out.ready) begin
						x_q     <= i_q;
						ftgt_q  <= F_OUT;
						state_q <= S_FIND;
					end
				end
				S_OMAP: state_q <= S_ORK;
				S_ORK: state_q <= S_OOUT;
				S_OOUT: begin
					if (!res_valid_q || block_out.ready) begin
						res_q.line_index <= OUT_W'(i_q);
						res_q.block_id   <= OUT_W'(map_rd_q);
						res_q.out_last   <= (CW'(i_q) + CW'(1) == n_q);
						if (CW'(i_q) + CW'(1) >= n_q) begin
							state_q <= S_LOAD;
						end else begin
							i_q     <= i_q + IW'(1);
							state_q <= S_OSTART;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end
endmodule

FILE: tb/sv/testbench.sv
// Testbench for the text line block grouper: directed table, random line sets, predictor.
`timescale 1ns / 1ps
module testbench;
	import tlbg_pkg::*;

	localparam int LINES_CAP = 64;
	localparam int IDLE_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #5 clk = ~clk;

	tlbg_if #(.payload_t(line_req_t)) line_in ();
	tlbg_if #(.payload_t(block_res_t)) block_out ();

	text_line_block_grouper dut (
		.clk(clk),
		.arst_n(arst_n),
		.line_in(line_in.sink),
		.block_out(block_out.source)
	);

	// Predictor state: the lines loaded in the current set.
	line_req_t set_lines[$];
	block_res_t block_expect_q[$];
	int mismatch_count = 0;
	int idle_cycles = 0;
	bit quiet_phase = 0;
	bit hold_sink = 0;

	task automatic report(input string what);
		$display("mismatch: %s at %0t", what, $time);
		mismatch_count++;
	endtask

	function automatic longint iabs(input longint x);
		return x < 0 ? -x : x;
	endfunction

	// Merge test for one pair of stored lines, exact integer form of the thresholds.
	function automatic bit lines_join(input line_req_t a, input line_req_t b);
		longint ua, ub, va, vb, wa, wb, ha, hb, big_h, small_h, max_w, min_w, g2, cd;
		bit similar, left_ok, right_ok, centered, strong_c, close_g, height_ok;
		ua = a.pos_u; ub = b.pos_u; va = a.pos_v; vb = b.pos_v;
		wa = a.box_w; wb = b.box_w; ha = a.box_h; hb = b.box_h;
		big_h = ha > hb ? ha : hb; small_h = ha > hb ? hb : ha;
		max_w = wa > wb ? wa : wb; min_w = wa > wb ? wb : wa;
		g2 = 2 * iabs(vb - va) - (ha + hb);
		cd = iabs(ua - ub);
		if (100 * g2 < -150 * big_h || 100 * g2 > 850 * big_h) return 0;
		centered = 100 * cd <= 25 * max_w;
		similar = 10 * max_w <= 18 * min_w;
		left_ok = similar && iabs((2 * ua - wa) - (2 * ub - wb)) <= 4 * big_h;
		right_ok = similar && iabs((2 * ua + wa) - (2 * ub + wb)) <= 4 * big_h;
		strong_c = 100 * cd <= 12 * max_w;
		close_g = 100 * g2 <= 250 * big_h;
		height_ok = 10 * big_h <= 18 * small_h ||
			(10 * big_h <= 22 * small_h && strong_c && close_g);
		return height_ok && (centered || left_ok || right_ok);
	endfunction

	// Group the stored set and queue one block number per line in load order.
	task automatic group_set();
		int n, r, rank;
		int parent[LINES_CAP];
		bit seen[LINES_CAP];
		longint key_v[LINES_CAP], key_u[LINES_CAP];
		int root_of[LINES_CAP];
		block_res_t res;
		n = set_lines.size();
		for (int i = 0; i < n; i++) begin
			parent[i] = i;
			seen[i] = 0;
		end
		for (int i = 0; i < n; i++) begin
			if (set_lines[i].is_measure) continue;
			for (int j = i + 1; j < n; j++) begin
				int up, ri, rj;
				if (set_lines[j].is_measure) continue;
				if (set_lines[i].read_quadrant != set_lines[j].read_quadrant) continue;
				if (!lines_join(set_lines[i], set_lines[j])) continue;
				up = set_lines[i].pos_v <= set_lines[j].pos_v ? i : j;
				if (set_lines[up].is_heading) continue;
				rj = j;
				while (parent[rj] != rj) begin
					parent[rj] = parent[parent[rj]];
					rj = parent[rj];
				end
				ri = i;
				while (parent[ri] != ri) begin
					parent[ri] = parent[parent[ri]];
					ri = parent[ri];
				end
				parent[ri] = rj;
			end
		end
		for (int i = 0; i < n; i++) begin
			r = i;
			while (parent[r] != r) r = parent[r];
			root_of[i] = r;
			if (!seen[r]) begin
				seen[r] = 1;
				key_v[r] = set_lines[i].pos_v;
				key_u[r] = set_lines[i].pos_u;
			end
			if (set_lines[i].pos_v < key_v[r]) key_v[r] = set_lines[i].pos_v;
			if (set_lines[i].pos_u < key_u[r]) key_u[r] = set_lines[i].pos_u;
		end
		for (int i = 0; i < n; i++) begin
			r = root_of[i];
			rank = 0;
			for (int k = 0; k < n; k++)
				if (seen[k] && (key_v[k] < key_v[r] ||
					(key_v[k] == key_v[r] && (key_u[k] < key_u[r] ||
					(key_u[k] == key_u[r] && k < r)))))
					rank++;
			res.line_index = i[5:0];
			res.block_id = rank[5:0];
			res.out_last = (i == n - 1);
			block_expect_q.insert(block_expect_q.size(), res);
		end
		set_lines.delete();
	endtask

	// Accepted requests update the predictor; sizes below one pixel are raised.
	task automatic take_line(input line_req_t req);
		line_req_t s;
		s = req;
		if (s.box_w < 16) s.box_w = SIZE_W'(16);
		if (s.box_h < 16) s.box_h = SIZE_W'(16);
		if (set_lines.size() < LINES_CAP) set_lines.insert(set_lines.size(), s);
		if (req.in_last) group_set();
	endtask

	always @(posedge clk) begin
		if (arst_n && line_in.valid && line_in.ready) take_line(line_in.payload);
		if (arst_n && block_out.valid && block_out.ready) begin
			if (block_expect_q.size() == 0)
				report("result with nothing expected");
			else begin
				block_res_t e;
				e = block_expect_q.pop_front();
				if (block_out.payload.line_index !== e.line_index) report("line_index");
				if (block_out.payload.block_id !== e.block_id)
					report($sformatf("block_id line %0d got %0d want %0d",
						e.line_index, block_out.payload.block_id, e.block_id));
				if (block_out.payload.out_last !== e.out_last) report("out_last");
			end
		end
	end

	// Watchdog on cycles without any accepted request or result.
	always @(posedge clk) begin
		if ((line_in.valid && line_in.ready) || (block_out.valid && block_out.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL text_line_block_grouper");
			$finish;
		end
	end

	// Result side: random stall bursts, plus a long hold-off when asked.
	initial begin
		block_out.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_sink) begin
				block_out.ready <= 1'b0;
			end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
				block_out.ready <= 1'b0;
				repeat ($urandom_range(1, 10) - 1) @(negedge clk);
			end else begin
				block_out.ready <= 1'b1;
			end
		end
	end

	// Drive one request at a falling edge and wait for its acceptance, with an optional
	// idle burst first. Valid stays high afterwards until the next request or a pause.
	task automatic send_line(input line_req_t req);
		if (!quiet_phase && $urandom_range(0, 4) == 0) begin
			line_in.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		line_in.payload <= req;
		line_in.valid <= 1'b1;
		do @(posedge clk); while (!line_in.ready);
		@(negedge clk);
	endtask

	// Drop valid and wait until every expected result has come.
	task automatic pause_line();
		line_in.valid <= 1'b0;
		wait (block_expect_q.size() == 0);
		@(negedge clk);
	endtask

	function automatic line_req_t mk_line(input int u, input int v, input int w, input int h,
		input int q, input bit m, input bit hd, input bit last);
		line_req_t r;
		r.pos_u = POS_W'(u); r.pos_v = POS_W'(v); r.box_w = SIZE_W'(w); r.box_h = SIZE_W'(h);
		r.read_quadrant = 2'(q); r.is_measure = m; r.is_heading = hd; r.in_last = last;
		return r;
	endfunction

	// A random well-formed paragraph-like set, with occasional wild lines.
	task automatic random_set(input int n);
		int base_u, base_v, h, w, v;
		int q;
		base_u = $urandom_range(0, 4000) - 2000;
		base_v = $urandom_range(0, 4000) - 2000;
		q = $urandom_range(0, 3);
		v = base_v;
		for (int i = 0; i < n; i++) begin
			line_req_t r;
			h = $urandom_range(100, 300);
			w = $urandom_range(800, 2000);
			if ($urandom_range(0, 9) == 0)
				r = mk_line($urandom, $urandom, $urandom, $urandom, $urandom,
					1'($urandom), 1'($urandom), i == n - 1);
			else
				r = mk_line(base_u + $urandom_range(0, 300) - 150, v, w, h,
					$urandom_range(0, 7) == 0 ? $urandom_range(0, 3) : q,
					$urandom_range(0, 11) == 0, $urandom_range(0, 9) == 0, i == n - 1);
			v += h + $urandom_range(0, 3 * h);
			if ($urandom_range(0, 5) == 0) v += 2000;
			send_line(r);
		end
	endtask

	line_req_t dir_tab[$];

	function automatic void add_row(input line_req_t r);
		dir_tab.insert(dir_tab.size(), r);
	endfunction

	initial begin
		int sent;
		line_in.valid = 1'b0;
		line_in.payload = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table. A lone line is always block zero and last.
		add_row(mk_line(0, 0, 0, 0, 0, 0, 0, 1));
		add_row(mk_line(-524288, -524288, 65535, 65535, 3, 1, 1, 1));
		add_row(mk_line(524287, 524287, 0, 65535, 2, 0, 1, 1));
		// Two stacked lines merge; heading on top blocks; measurement never merges.
		add_row(mk_line(100, 0, 1600, 160, 1, 0, 0, 0));
		add_row(mk_line(100, 200, 1600, 160, 1, 0, 0, 1));
		add_row(mk_line(100, 0, 1600, 160, 1, 0, 1, 0));
		add_row(mk_line(100, 200, 1600, 160, 1, 0, 0, 1));
		add_row(mk_line(100, 200, 1600, 160, 1, 0, 1, 0));
		add_row(mk_line(100, 0, 1600, 160, 1, 1, 0, 1));
		// Equal v with heading on the earlier line; different quadrants.
		add_row(mk_line(0, 500, 1000, 160, 0, 0, 1, 0));
		add_row(mk_line(0, 500, 1000, 160, 0, 0, 0, 0));
		add_row(mk_line(0, 700, 1000, 160, 2, 0, 0, 0));
		add_row(mk_line(40, 680, 1100, 300, 0, 0, 0, 1));
		// Height ratio near 1.8 and 2.2 and edge-aligned narrow lines.
		add_row(mk_line(0, 0, 1000, 100, 0, 0, 0, 0));
		add_row(mk_line(500, 150, 600, 180, 0, 0, 0, 0));
		add_row(mk_line(10, 300, 1000, 220, 0, 0, 0, 0));
		add_row(mk_line(200, -900, 30000, 65535, 0, 0, 0, 1));
		foreach (dir_tab[i]) begin
			if (i < 3) pause_line();
			send_line(dir_tab[i]);
			if (i < 3) begin
				if (block_expect_q.size() != 1 || block_expect_q[0] != 13'b000000_000000_1)
					report("single line set");
			end
		end

		// Store full: 66 lines, the last two dropped, in_last on a dropped one.
		for (int i = 0; i < 66; i++)
			send_line(mk_line(i * 7, i * 200, 1000 + i, 160, 0, i % 9 == 0, 0, i == 65));

		// Long receiver hold-off while the sender keeps offering lines.
		hold_sink = 1;
		fork
			begin
				repeat (3000) @(negedge clk);
				hold_sink = 0;
			end
			begin
				random_set(3);
				random_set(4);
				line_in.valid <= 1'b0;
			end
		join

		// Sender pause until everything has drained.
		wait (block_expect_q.size() == 0);
		@(negedge clk);
		sent = 0;
		while (sent < 170) begin
			int n;
			n = $urandom_range(0, 15) == 0 ? $urandom_range(16, 40) : $urandom_range(1, 8);
			if (sent > 140) quiet_phase = 1;
			random_set(n);
			sent += n;
		end

		pause_line();
		repeat (200) @(posedge clk);
		if (mismatch_count == 0 && set_lines.size() == 0)
			$display("PASS text_line_block_grouper");
		else
			$display("FAIL text_line_block_grouper");
		$finish;
	end
endmodule

FILE: text_line_block_grouper.f
rtl/tlbg_pkg.sv
rtl/tlbg_if.sv
rtl/tlbg_pair.sv
rtl/text_line_block_grouper.sv
tb/sv/testbench.sv
